>>> rtl/cdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_pkg: shared types and constants of the connection table
// Item formats, operation and class codes, the bucket hash and slot record.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int DEF_BUCKETS      = 64;
  localparam int DEF_SLOTS        = 8;
  localparam int DEF_CONN_ID_BITS = 10;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [2:0] CL_EXACT = 3'd0;
  localparam logic [2:0] CL_PA    = 3'd1;
  localparam logic [2:0] CL_PORT  = 3'd2;
  localparam logic [2:0] CL_ADDR  = 3'd3;
  localparam logic [2:0] CL_ANY   = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] remote_addr_hi;
    logic [63:0] remote_addr_lo;
    logic [15:0] remote_port;
    logic [63:0] local_addr_hi;
    logic [63:0] local_addr_lo;
    logic [15:0] local_port;
    logic [9:0]  conn_id;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [9:0] found_conn;
    logic [2:0] match_class;
    logic       table_full;
  } out_item_t;

  // Decoded command handed from the front end to the engine.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  add_class;
    logic [31:0] key0;  // full-tuple key
    logic [31:0] key1;  // local address and port
    logic [31:0] key2;  // port only
    logic [31:0] key3;  // address only
    in_item_t    item;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  cls;
    logic [63:0] rhi;
    logic [63:0] rlo;
    logic [15:0] rp;
    logic [63:0] lhi;
    logic [63:0] llo;
    logic [15:0] lp;
    logic [15:0] conn;
  } slot_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MOD, ST_WAIT, ST_EVAL, ST_WRITE, ST_OUT
  } eng_state_t;

  function automatic logic [31:0] hash_key(logic [7:0] rlo, logic [15:0] rp,
                                           logic [7:0] llo, logic [15:0] lp);
    hash_key = {rlo, 24'd0} ^ {rp, 16'd0} ^ {16'd0, llo, 8'd0} ^ {16'd0, lp};
  endfunction

endpackage

>>> rtl/connection_demux_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_demux_table_core: hashed connection table
// Front classifier, command queue and table engine.
// ----------------------------------------------------------------------------
// Items are handled one at a time by the engine: an add that finds a free slot
// or a remove that finds its entry passes READ, MOD, WAIT, EVAL, WRITE and OUT,
// other adds and removes skip WRITE, and a lookup repeats READ to EVAL for each
// probed bucket, up to five probes. The bucket index is computed in READ and
// MOD, and the single read port of the bucket memory is used in WAIT. An item
// passes the classifier register and the command queue before the engine takes
// it; the two keep accepting items while the engine works, until both are full.
// No clearing pass is needed after reset; slot valid bits clear at once.
module connection_demux_table_core
  import cdt_pkg::*;
#(
  parameter int BUCKETS      = DEF_BUCKETS,
  parameter int SLOTS        = DEF_SLOTS,
  parameter int CONN_ID_BITS = DEF_CONN_ID_BITS
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  logic fr_valid, fr_take, q_valid, q_take;
  cmd_t fr_cmd, q_cmd;

  cdt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(push), .in_full(full), .in_data(in_data),
    .cmd_valid(fr_valid), .cmd_take(fr_take), .cmd(fr_cmd)
  );

  cdt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(fr_valid), .wr_take(fr_take), .wr_cmd(fr_cmd),
    .rd_valid(q_valid), .rd_take(q_take), .rd_cmd(q_cmd)
  );

  cdt_engine #(
    .BUCKETS(BUCKETS), .SLOTS(SLOTS), .CONN_ID_BITS(CONN_ID_BITS)
  ) u_engine (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_cmd),
    .out_empty(empty), .out_pop(pop), .out_data(out_data)
  );

endmodule

>>> rtl/cdt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_front: classifier
// Registers an accepted item with its add class and the four hash keys.
// ----------------------------------------------------------------------------
module cdt_front
  import cdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_take,
  output cmd_t     cmd
);

  logic valid_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic rset;
  logic lset;

  assign in_full   = valid_r && !cmd_take;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    rset = (in_data.remote_addr_hi | in_data.remote_addr_lo) != 64'd0;
    lset = (in_data.local_addr_hi | in_data.local_addr_lo) != 64'd0;
    cmd_nxt.kind = in_data.kind;
    cmd_nxt.item = in_data;
    if (rset) begin
      cmd_nxt.add_class = CL_EXACT;
    end else if (lset) begin
      cmd_nxt.add_class = (in_data.local_port == 16'd0) ? CL_ADDR : CL_PA;
    end else begin
      cmd_nxt.add_class = (in_data.local_port == 16'd0) ? CL_ANY : CL_PORT;
    end
    cmd_nxt.key0 = hash_key(in_data.remote_addr_lo[7:0], in_data.remote_port,
                            in_data.local_addr_lo[7:0], in_data.local_port);
    cmd_nxt.key1 = hash_key(8'd0, 16'd0, in_data.local_addr_lo[7:0], in_data.local_port);
    cmd_nxt.key2 = hash_key(8'd0, 16'd0, 8'd0, in_data.local_port);
    cmd_nxt.key3 = hash_key(8'd0, 16'd0, in_data.local_addr_lo[7:0], 16'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_push && !in_full) begin
      valid_r <= 1'b1;
    end else if (cmd_take) begin
      valid_r <= 1'b0;
    end
    if (in_push && !in_full) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

>>> rtl/cdt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_queue: command queue
// Small FIFO between the classifier and the table engine.
// ----------------------------------------------------------------------------
module cdt_queue
  import cdt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_take,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_take,
  output cmd_t rd_cmd
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [AW:0]   cnt_r;

  assign wr_take  = wr_valid && (cnt_r != AW'(0) + (AW+1)'(QUEUE_DEPTH));
  assign rd_valid = cnt_r != '0;
  assign rd_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_take) begin
        wp_r <= (wp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_take) begin
        rp_r <= (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr_take) - (AW+1)'(rd_take);
    end
    if (wr_take) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

endmodule

>>> rtl/cdt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_engine: table engine
// Holds the slot store, one bucket per memory row, and carries out add,
// remove and the five-probe lookup, one bucket read per probe.
// ----------------------------------------------------------------------------
module cdt_engine
  import cdt_pkg::*;
#(
  parameter int BUCKETS      = DEF_BUCKETS,
  parameter int SLOTS        = DEF_SLOTS,
  parameter int CONN_ID_BITS = DEF_CONN_ID_BITS
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_take,
  input  cmd_t      cmd,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW = $clog2(SLOTS + 1);
  // Scaled reciprocal of the bucket count; the quotient it gives is low by
  // at most one, so one compare and subtract finishes the remainder.
  localparam int          SH    = 32 + BW;
  localparam logic [33:0] RECIP = 34'((66'd1 << SH) / BUCKETS);

  typedef logic [SLOTS-1:0][$bits(slot_rec_t)-1:0] row_t;

  row_t                          mem_r [BUCKETS];
  logic [BUCKETS-1:0][SLOTS-1:0] valid_r;
  logic [SLOTS-1:0][RW-1:0]      rank_r [BUCKETS];

  eng_state_t state_r, state_nxt;
  cmd_t       cur_r;
  logic [2:0] probe_r, probe_nxt;
  logic [BW-1:0] bkt_r, bkt_nxt;
  row_t       row_r;
  logic [SLOTS-1:0][RW-1:0] rank_rd_r;
  logic [SLOTS-1:0] vrow_r;
  logic       found_r, found_nxt;
  logic [SW-1:0] sel_r, sel_nxt;
  out_item_t  res_r, res_nxt;
  out_item_t  out_r;
  logic       full_r, full_nxt;
  logic       load;
  logic       wr_en;
  logic [65:0] prod_r;

  slot_rec_t  rec [SLOTS];
  logic [SLOTS-1:0] match;
  logic [31:0] key;
  slot_rec_t  new_rec;
  logic [15:0] id;
  logic [31:0] quo;
  logic [32:0] rem;
  logic [BW-1:0] bkt_mod;

  assign out_empty = !full_r;
  assign out_data  = out_r;
  assign id        = 16'(cur_r.item.conn_id[CONN_ID_BITS-1:0]);

  always_comb begin
    case (probe_r)
      3'd0: key = cur_r.key0;
      3'd1: key = cur_r.key1;
      3'd2: key = cur_r.key2;
      3'd3: key = cur_r.key3;
      default: key = 32'd0;
    endcase
  end

  always_comb begin
    quo     = 32'(prod_r >> SH);
    rem     = 33'(key) - 33'(quo) * 33'(BUCKETS);
    bkt_mod = (rem >= 33'(BUCKETS)) ? BW'(rem - 33'(BUCKETS)) : BW'(rem);
  end

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      rec[s] = slot_rec_t'(row_r[s]);
    end
    for (int s = 0; s < SLOTS; s++) begin
      match[s] = 1'b0;
      if (vrow_r[s]) begin
        if (cur_r.kind == KIND_REMOVE) begin
          match[s] = rec[s].conn == id;
        end else if (rec[s].cls == probe_r) begin
          case (probe_r)
            CL_EXACT: match[s] = rec[s].rp == cur_r.item.remote_port
                && rec[s].lp == cur_r.item.local_port
                && rec[s].rhi == cur_r.item.remote_addr_hi
                && rec[s].rlo == cur_r.item.remote_addr_lo
                && rec[s].lhi == cur_r.item.local_addr_hi
                && rec[s].llo == cur_r.item.local_addr_lo;
            CL_PA: match[s] = rec[s].lp == cur_r.item.local_port
                && rec[s].lhi == cur_r.item.local_addr_hi
                && rec[s].llo == cur_r.item.local_addr_lo;
            CL_PORT: match[s] = rec[s].lp == cur_r.item.local_port;
            CL_ADDR: match[s] = rec[s].lhi == cur_r.item.local_addr_hi
                && rec[s].llo == cur_r.item.local_addr_lo;
            default: match[s] = 1'b1;
          endcase
        end
      end
    end
    new_rec.cls  = cur_r.add_class;
    new_rec.rhi  = cur_r.item.remote_addr_hi;
    new_rec.rlo  = cur_r.item.remote_addr_lo;
    new_rec.rp   = cur_r.item.remote_port;
    new_rec.lhi  = cur_r.item.local_addr_hi;
    new_rec.llo  = cur_r.item.local_addr_lo;
    new_rec.lp   = cur_r.item.local_port;
    new_rec.conn = id;
  end

  always_comb begin
    state_nxt = state_r;
    probe_nxt = probe_r;
    bkt_nxt   = bkt_r;
    found_nxt = found_r;
    sel_nxt   = sel_r;
    res_nxt   = res_r;
    load      = 1'b0;
    cmd_take  = 1'b0;
    wr_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take  = 1'b1;
          load      = 1'b1;
          probe_nxt = 3'd0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (cur_r.kind != KIND_ADD && cur_r.kind != KIND_REMOVE
            && cur_r.kind != KIND_LOOKUP) begin
          res_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        bkt_nxt   = bkt_mod;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: state_nxt = ST_EVAL;
      ST_EVAL: begin
        found_nxt = 1'b0;
        res_nxt   = '0;
        if (cur_r.kind == KIND_ADD) begin
          for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!vrow_r[s]) begin
              found_nxt = 1'b1;
              sel_nxt   = SW'(s);
            end
          end
          res_nxt.match_class = cur_r.add_class;
          res_nxt.hit         = found_nxt;
          res_nxt.table_full  = !found_nxt;
          state_nxt = found_nxt ? ST_WRITE : ST_OUT;
        end else begin
          for (int s = 0; s < SLOTS; s++) begin
            if (match[s] && (!found_nxt || rank_rd_r[s] < rank_rd_r[sel_nxt])) begin
              found_nxt = 1'b1;
              sel_nxt   = SW'(s);
            end
          end
          if (found_nxt) begin
            res_nxt.hit         = 1'b1;
            res_nxt.match_class = rec[sel_nxt].cls;
            if (cur_r.kind == KIND_LOOKUP) begin
              res_nxt.found_conn = 10'(rec[sel_nxt].conn);
            end
            state_nxt = (cur_r.kind == KIND_REMOVE) ? ST_WRITE : ST_OUT;
          end else if (cur_r.kind == KIND_LOOKUP && probe_r != CL_ANY) begin
            probe_nxt = probe_r + 3'd1;
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_WRITE: begin
        wr_en     = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!full_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      full_r  <= 1'b0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && !full_r) begin
        full_r <= 1'b1;
      end else if (out_pop) begin
        full_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[bkt_r][sel_r] <= (cur_r.kind == KIND_ADD);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= cmd;
    end
    probe_r <= probe_nxt;
    bkt_r   <= bkt_nxt;
    found_r <= found_nxt;
    sel_r   <= sel_nxt;
    res_r   <= res_nxt;
    // The result register is only loaded once the previous item has left.
    if (state_r == ST_OUT && !full_r) begin
      out_r <= res_r;
    end
    if (state_r == ST_READ) begin
      prod_r <= 66'(key) * 66'(RECIP);
    end
    if (state_r == ST_WAIT) begin
      row_r     <= mem_r[bkt_r];
      rank_rd_r <= rank_r[bkt_r];
      vrow_r    <= valid_r[bkt_r];
    end
    if (wr_en) begin
      if (cur_r.kind == KIND_ADD) begin
        mem_r[bkt_r][sel_r] <= new_rec;
      end
      for (int s = 0; s < SLOTS; s++) begin
        if (cur_r.kind == KIND_ADD) begin
          if (SW'(s) == sel_r) begin
            rank_r[bkt_r][s] <= '0;
          end else if (vrow_r[s]) begin
            rank_r[bkt_r][s] <= rank_rd_r[s] + 1'b1;
          end
        end else if (vrow_r[s] && rank_rd_r[s] > rank_rd_r[sel_r]) begin
          rank_r[bkt_r][s] <= rank_rd_r[s] - 1'b1;
        end
      end
    end
  end

endmodule

>>> tb/connection_demux_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_demux_table_core_test: connection table testbench
// Drives add, remove, lookup and bad-kind items through the queue interface,
// predicts every result with a behavioral copy of the table, and compares each
// popped result field by field. Both sides idle at random while stalls are on.
// ----------------------------------------------------------------------------
module connection_demux_table_core_test;
  import cdt_pkg::*;

  localparam int NB = DEF_BUCKETS;
  localparam int NS = DEF_SLOTS;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;

  connection_demux_table_core dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  // Shadow copy of the table.
  logic       tbl_valid [NB*NS];
  logic [2:0] tbl_rank  [NB*NS];
  logic [2:0] tbl_class [NB*NS];
  in_item_t   tbl_entry [NB*NS];

  out_item_t expected_results[$];
  int        errors;
  bit        stall_enable;

  // Addresses and ports drawn from small pools so that lookups hit often.
  logic [63:0] addr_pool [8];
  logic [15:0] port_pool [4];
  logic [9:0]  id_pool   [6];

  initial begin
    clk = 1'b0;
  end
  always #6 clk = ~clk;

  function automatic int bucket_of(logic [7:0] rlo, logic [15:0] rp,
                                   logic [7:0] llo, logic [15:0] lp);
    logic [31:0] v;
    v = {rlo, 24'd0} ^ {rp, 16'd0} ^ {16'd0, llo, 8'd0} ^ {16'd0, lp};
    return int'(v % NB);
  endfunction

  function automatic int probe_bucket(int b, logic [2:0] cl, in_item_t it);
    int  best;
    int  i;
    bit  ok;
    best = -1;
    for (int s = 0; s < NS; s++) begin
      i = b * NS + s;
      if (tbl_valid[i] && tbl_class[i] == cl) begin
        case (cl)
          CL_EXACT: ok = tbl_entry[i].remote_addr_hi == it.remote_addr_hi &&
                         tbl_entry[i].remote_addr_lo == it.remote_addr_lo &&
                         tbl_entry[i].remote_port == it.remote_port &&
                         tbl_entry[i].local_addr_hi == it.local_addr_hi &&
                         tbl_entry[i].local_addr_lo == it.local_addr_lo &&
                         tbl_entry[i].local_port == it.local_port;
          CL_PA:    ok = tbl_entry[i].local_addr_hi == it.local_addr_hi &&
                         tbl_entry[i].local_addr_lo == it.local_addr_lo &&
                         tbl_entry[i].local_port == it.local_port;
          CL_PORT:  ok = tbl_entry[i].local_port == it.local_port;
          CL_ADDR:  ok = tbl_entry[i].local_addr_hi == it.local_addr_hi &&
                         tbl_entry[i].local_addr_lo == it.local_addr_lo;
          default:  ok = 1'b1;
        endcase
        if (ok && (best < 0 || tbl_rank[i] < tbl_rank[best])) best = i;
      end
    end
    return best;
  endfunction

  function automatic out_item_t apply_to_table(in_item_t it);
    out_item_t  r;
    int         b;
    int         f;
    int         i;
    logic [2:0] cl;
    logic [2:0] rk;
    r = '0;
    b = bucket_of(it.remote_addr_lo[7:0], it.remote_port, it.local_addr_lo[7:0],
                  it.local_port);
    case (it.kind)
      KIND_ADD: begin
        if ({it.remote_addr_hi, it.remote_addr_lo} != 0) cl = CL_EXACT;
        else if ({it.local_addr_hi, it.local_addr_lo} != 0)
          cl = (it.local_port == 0) ? CL_ADDR : CL_PA;
        else cl = (it.local_port == 0) ? CL_ANY : CL_PORT;
        r.match_class = cl;
        f = -1;
        for (int s = 0; s < NS; s++)
          if (f < 0 && !tbl_valid[b*NS+s]) f = b * NS + s;
        if (f < 0) begin
          r.table_full = 1'b1;
        end else begin
          for (int s = 0; s < NS; s++)
            if (tbl_valid[b*NS+s]) tbl_rank[b*NS+s]++;
          tbl_valid[f] = 1'b1;
          tbl_rank[f]  = '0;
          tbl_class[f] = cl;
          tbl_entry[f] = it;
          r.hit = 1'b1;
        end
      end
      KIND_REMOVE: begin
        f = -1;
        for (int s = 0; s < NS; s++) begin
          i = b * NS + s;
          if (tbl_valid[i] && tbl_entry[i].conn_id == it.conn_id &&
              (f < 0 || tbl_rank[i] < tbl_rank[f])) f = i;
        end
        if (f >= 0) begin
          rk = tbl_rank[f];
          r.match_class = tbl_class[f];
          tbl_valid[f] = 1'b0;
          for (int s = 0; s < NS; s++)
            if (tbl_valid[b*NS+s] && tbl_rank[b*NS+s] > rk) tbl_rank[b*NS+s]--;
          r.hit = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        f = probe_bucket(b, CL_EXACT, it);
        if (f < 0) f = probe_bucket(bucket_of(0, 0, it.local_addr_lo[7:0],
                                              it.local_port), CL_PA, it);
        if (f < 0) f = probe_bucket(bucket_of(0, 0, 0, it.local_port), CL_PORT, it);
        if (f < 0) f = probe_bucket(bucket_of(0, 0, it.local_addr_lo[7:0], 0),
                                    CL_ADDR, it);
        if (f < 0) f = probe_bucket(bucket_of(0, 0, 0, 0), CL_ANY, it);
        if (f >= 0) begin
          r.hit        = 1'b1;
          r.found_conn = tbl_entry[f].conn_id;
          r.match_class = tbl_class[f];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (!stall_enable || p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_item(in_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_results.push_back(apply_to_table(it));
    @(negedge clk);
  endtask

  // Result side: random pop stalls, compare on each accepted result.
  initial begin
    out_item_t want;
    int        g;
    pop = 1'b0;
    @(negedge clk);
    forever begin
      g = gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.hit != want.hit)
            report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
          if (out_data.found_conn != want.found_conn)
            report_mismatch("found_conn", 32'(out_data.found_conn),
                            32'(want.found_conn));
          if (out_data.match_class != want.match_class)
            report_mismatch("match_class", 32'(out_data.match_class),
                            32'(want.match_class));
          if (out_data.table_full != want.table_full)
            report_mismatch("table_full", 32'(out_data.table_full),
                            32'(want.table_full));
        end
      end
      @(negedge clk);
    end
  end

  function automatic in_item_t make_item(logic [1:0] k, logic [63:0] rhi,
                                         logic [63:0] rlo, logic [15:0] rp,
                                         logic [63:0] lhi, logic [63:0] llo,
                                         logic [15:0] lp, logic [9:0] id);
    in_item_t it;
    it.kind = k;
    it.remote_addr_hi = rhi;
    it.remote_addr_lo = rlo;
    it.remote_port = rp;
    it.local_addr_hi = lhi;
    it.local_addr_lo = llo;
    it.local_port = lp;
    it.conn_id = id;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Tuple from the pools, with the addresses and the local port sometimes left unset.
  function automatic in_item_t pooled_item(logic [1:0] k);
    logic [63:0] rhi;
    logic [63:0] rlo;
    logic [63:0] lhi;
    logic [63:0] llo;
    logic [15:0] lp;
    rhi = 0;
    rlo = 0;
    lhi = 0;
    llo = 0;
    lp  = 0;
    if ($urandom_range(2) == 0) begin
      rhi = addr_pool[$urandom_range(7)];
      rlo = addr_pool[$urandom_range(7)];
    end
    if ($urandom_range(2) != 0) begin
      lhi = addr_pool[$urandom_range(7)];
      llo = addr_pool[$urandom_range(7)];
    end
    if ($urandom_range(3) != 0) lp = port_pool[$urandom_range(3)];
    return make_item(k, rhi, rlo, port_pool[$urandom_range(3)], lhi, llo, lp,
                     id_pool[$urandom_range(5)]);
  endfunction

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    stall_enable = 1'b0;
    // Miss on an empty table, then one entry of each class.
    send_item(make_item(KIND_LOOKUP, 5, 6, 7, 8, 9, 10, 0));
    send_item(make_item(KIND_ADD, ones, ones, 16'hffff, ones, ones, 16'hffff, 10'h3ff));
    send_item(make_item(KIND_ADD, 0, 0, 0, ones, ones, 16'hffff, 10'h001));
    send_item(make_item(KIND_ADD, 0, 0, 0, 0, 0, 16'h0050, 10'h002));
    send_item(make_item(KIND_ADD, 0, 0, 0, 64'h1, 64'h2, 0, 10'h003));
    send_item(make_item(KIND_ADD, 0, 0, 0, 0, 0, 0, 10'h004));
    // Lookups landing on each class in precedence order.
    send_item(make_item(KIND_LOOKUP, ones, ones, 16'hffff, ones, ones, 16'hffff, 0));
    send_item(make_item(KIND_LOOKUP, 64'h7, 64'h7, 16'h7, ones, ones, 16'hffff, 10'h3ff));
    send_item(make_item(KIND_LOOKUP, 64'h7, 64'h7, 16'h7, 0, 64'h5, 16'h0050, 0));
    send_item(make_item(KIND_LOOKUP, 0, 0, 16'h7, 64'h1, 64'h2, 16'h0099, 0));
    send_item(make_item(KIND_LOOKUP, 0, 0, 0, 64'h3, 64'h3, 16'h0099, 0));
    // Fill one bucket past capacity with duplicate ids, then remove.
    for (int n = 0; n < NS + 1; n++)
      send_item(make_item(KIND_ADD, 0, 0, 0, 0, 0, 0, (n % 2) ? 10'h00a : 10'h00b));
    send_item(make_item(KIND_REMOVE, 0, 0, 0, 0, 0, 0, 10'h00a));
    send_item(make_item(KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_REMOVE, 0, 0, 0, 0, 0, 0, 10'h3fe));
    send_item(make_item(2'd3, ones, ones, 16'hffff, ones, ones, 16'hffff, 10'h3ff));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    in_item_t it;
    int       p;
    stall_enable = 1'b1;
    for (int n = 0; n < 1150; n++) begin
      if (n % 200 == 0) stall_enable = ($urandom_range(3) != 0);
      p = $urandom_range(99);
      if (p < 40) it = pooled_item(KIND_ADD);
      else if (p < 65) it = pooled_item(KIND_REMOVE);
      else if (p < 92) it = pooled_item(KIND_LOOKUP);
      else begin
        // Wide-open noise: every bit of every field gets exercised.
        it = make_item(2'($urandom_range(3)), rand64(), rand64(), 16'($urandom),
                       rand64(), rand64(), 16'($urandom), 10'($urandom));
      end
      send_item(it);
    end
    wait_drained();
  endtask

  initial begin
    errors       = 0;
    stall_enable = 1'b0;
    rst_n        = 1'b0;
    push         = 1'b0;
    in_data      = '0;
    for (int i = 0; i < NB * NS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_rank[i]  = '0;
      tbl_class[i] = '0;
      tbl_entry[i] = '0;
    end
    for (int i = 0; i < 8; i++) addr_pool[i] = (i == 0) ? 64'h0 : {$urandom, $urandom};
    for (int i = 0; i < 4; i++) port_pool[i] = 16'($urandom);
    for (int i = 0; i < 6; i++) id_pool[i] = 10'($urandom);
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_traffic();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/cdt_pkg.sv
rtl/cdt_front.sv
rtl/cdt_queue.sv
rtl/cdt_engine.sv
rtl/connection_demux_table_core.sv
tb/connection_demux_table_core_test.sv
